### rtl/exlex_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Expression lexer package
// Shared widths, token record, character and kind codes, and the small
// character classification functions used by the lexer step logic.
// ----------------------------------------------------------------------------
package exlex_pkg;

    localparam int POSITION_BITS = 32;
    localparam int LENGTH_BITS   = 16;
    localparam int KIND_BITS     = 5;

    // Token queue geometry
    localparam int TQ_DEPTH      = 4;
    localparam int TQ_PTR_BITS   = $clog2(TQ_DEPTH);
    localparam int TQ_CNT_BITS   = $clog2(TQ_DEPTH + 1);

    typedef struct packed {
        logic [KIND_BITS-1:0]     kind;
        logic [POSITION_BITS-1:0] start;
        logic [LENGTH_BITS-1:0]   len;
        logic                     last;
    } t_token;

    // Token kinds
    localparam logic [KIND_BITS-1:0] KIND_INT    = 5'd0;
    localparam logic [KIND_BITS-1:0] KIND_FOR    = 5'd1;
    localparam logic [KIND_BITS-1:0] KIND_ADD    = 5'd2;
    localparam logic [KIND_BITS-1:0] KIND_SUB    = 5'd3;
    localparam logic [KIND_BITS-1:0] KIND_MUL    = 5'd4;
    localparam logic [KIND_BITS-1:0] KIND_DIV    = 5'd5;
    localparam logic [KIND_BITS-1:0] KIND_ASSIGN = 5'd6;
    localparam logic [KIND_BITS-1:0] KIND_AND    = 5'd7;
    localparam logic [KIND_BITS-1:0] KIND_NE     = 5'd9;
    localparam logic [KIND_BITS-1:0] KIND_LT     = 5'd10;
    localparam logic [KIND_BITS-1:0] KIND_GT     = 5'd11;
    localparam logic [KIND_BITS-1:0] KIND_LE     = 5'd12;
    localparam logic [KIND_BITS-1:0] KIND_GE     = 5'd13;
    localparam logic [KIND_BITS-1:0] KIND_EQ     = 5'd14;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN = 5'd15;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN = 5'd16;
    localparam logic [KIND_BITS-1:0] KIND_COMMA  = 5'd17;
    localparam logic [KIND_BITS-1:0] KIND_SEMI   = 5'd18;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE = 5'd19;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE = 5'd20;
    localparam logic [KIND_BITS-1:0] KIND_ID     = 5'd21;
    localparam logic [KIND_BITS-1:0] KIND_NUM    = 5'd22;
    localparam logic [KIND_BITS-1:0] KIND_ERR    = 5'd23;

    // Held operator codes
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_ASSIGN = 3'd1;
    localparam logic [2:0] OP_LT     = 3'd2;
    localparam logic [2:0] OP_GT     = 3'd3;
    localparam logic [2:0] OP_NOT    = 3'd4;
    localparam logic [2:0] OP_AMP    = 3'd5;

    // Keyword match progress
    localparam logic [2:0] KW_NONE = 3'd0;
    localparam logic [2:0] KW_I    = 3'd1;
    localparam logic [2:0] KW_IN   = 3'd2;
    localparam logic [2:0] KW_INT  = 3'd3;
    localparam logic [2:0] KW_F    = 3'd4;
    localparam logic [2:0] KW_FO   = 3'd5;
    localparam logic [2:0] KW_FOR  = 3'd6;

    // Characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NOT    = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_I   = 8'h69;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_O   = 8'h6F;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_digit(c) || ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
               ((c >= CH_UC_A) && (c <= CH_UC_Z)) || (c == CH_UNDER);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        unique case (c)
            CH_PLUS:   k = KIND_ADD;
            CH_MINUS:  k = KIND_SUB;
            CH_STAR:   k = KIND_MUL;
            CH_SLASH:  k = KIND_DIV;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_COMMA:  k = KIND_COMMA;
            CH_SEMI:   k = KIND_SEMI;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            default:   k = KIND_ERR;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] hold_code(input logic [7:0] c);
        logic [2:0] h;
        unique case (c)
            CH_EQ:   h = OP_ASSIGN;
            CH_LT:   h = OP_LT;
            CH_GT:   h = OP_GT;
            CH_NOT:  h = OP_NOT;
            CH_AMP:  h = OP_AMP;
            default: h = OP_NONE;
        endcase
        return h;
    endfunction

    function automatic logic [KIND_BITS-1:0] lone_kind(input logic [2:0] op);
        logic [KIND_BITS-1:0] k;
        unique case (op)
            OP_ASSIGN: k = KIND_ASSIGN;
            OP_LT:     k = KIND_LT;
            OP_GT:     k = KIND_GT;
            default:   k = KIND_ERR;
        endcase
        return k;
    endfunction

    // Operator followed by '='
    function automatic logic [KIND_BITS-1:0] pair_kind(input logic [2:0] op);
        logic [KIND_BITS-1:0] k;
        unique case (op)
            OP_ASSIGN: k = KIND_EQ;
            OP_LT:     k = KIND_LE;
            OP_GT:     k = KIND_GE;
            OP_NOT:    k = KIND_NE;
            default:   k = KIND_INT;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

### rtl/exlex_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Expression lexer step
// Lexer state registers and the per-character logic that updates them and
// forms up to two tokens for one character.
// ----------------------------------------------------------------------------
module exlex_step
    import exlex_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_advance,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_end_of_input,
    output t_token           o_tok0,
    output t_token           o_tok1,
    output logic [1:0]       o_tok_count
);

    logic [LENGTH_BITS-1:0]   r_word_len,   n_word_len;
    logic [POSITION_BITS-1:0] r_word_start, n_word_start;
    logic                     r_first_digit, n_first_digit;
    logic                     r_all_digits, n_all_digits;
    logic [2:0]               r_kw,         n_kw;
    logic [2:0]               r_pend,       n_pend;
    logic [POSITION_BITS-1:0] r_pend_start, n_pend_start;
    logic [POSITION_BITS-1:0] r_pos,        n_pos;
    logic                     r_stopped,    n_stopped;

    logic   a_valid, b_valid, pair_done;
    t_token a_tok, b_tok;
    logic [7:0] c;

    assign c = i_char_code;

    always_comb begin
        n_word_len    = r_word_len;
        n_word_start  = r_word_start;
        n_first_digit = r_first_digit;
        n_all_digits  = r_all_digits;
        n_kw          = r_kw;
        n_pend        = r_pend;
        n_pend_start  = r_pend_start;
        n_pos         = r_pos;
        n_stopped     = r_stopped;
        a_valid       = 1'b0;
        b_valid       = 1'b0;
        a_tok         = '0;
        b_tok         = '0;
        pair_done     = 1'b0;

        if (i_end_of_input) begin
            // flush a held operator alone, drop a partial word, reset
            if (r_pend != OP_NONE) begin
                a_valid     = 1'b1;
                a_tok.kind  = lone_kind(r_pend);
                a_tok.start = r_pend_start;
                a_tok.len   = LENGTH_BITS'(1);
            end
            n_word_len    = '0;
            n_word_start  = '0;
            n_first_digit = 1'b0;
            n_all_digits  = 1'b1;
            n_kw          = KW_NONE;
            n_pend        = OP_NONE;
            n_pend_start  = '0;
            n_pos         = '0;
            n_stopped     = 1'b0;
        end else if (!r_stopped) begin
            n_pos = r_pos + POSITION_BITS'(1);

            if (r_pend != OP_NONE) begin
                n_pend      = OP_NONE;
                a_valid     = 1'b1;
                a_tok.start = r_pend_start;
                if (r_pend == OP_AMP && c == CH_AMP) begin
                    a_tok.kind = KIND_AND;
                    a_tok.len  = LENGTH_BITS'(2);
                    pair_done  = 1'b1;
                end else if (r_pend != OP_AMP && c == CH_EQ) begin
                    a_tok.kind = pair_kind(r_pend);
                    a_tok.len  = LENGTH_BITS'(2);
                    pair_done  = 1'b1;
                end else begin
                    a_tok.kind = lone_kind(r_pend);
                    a_tok.len  = LENGTH_BITS'(1);
                end
            end

            if (!pair_done) begin
                if (is_word(c)) begin
                    if (r_word_len == '0) begin
                        n_word_start  = r_pos;
                        n_first_digit = is_digit(c);
                        n_kw = (c == CH_LC_I) ? KW_I : (c == CH_LC_F) ? KW_F : KW_NONE;
                    end else if (r_word_len == LENGTH_BITS'(1)) begin
                        n_kw = (r_kw == KW_I && c == CH_LC_N) ? KW_IN :
                               (r_kw == KW_F && c == CH_LC_O) ? KW_FO : KW_NONE;
                    end else if (r_word_len == LENGTH_BITS'(2)) begin
                        n_kw = (r_kw == KW_IN && c == CH_LC_T) ? KW_INT :
                               (r_kw == KW_FO && c == CH_LC_R) ? KW_FOR : KW_NONE;
                    end else begin
                        n_kw = KW_NONE;
                    end
                    if (!is_digit(c)) begin
                        n_all_digits = 1'b0;
                    end
                    // saturate the length
                    if (r_word_len != '1) begin
                        n_word_len = r_word_len + LENGTH_BITS'(1);
                    end
                end else begin
                    if (r_word_len != '0) begin
                        a_valid     = 1'b1;
                        a_tok.start = r_word_start;
                        a_tok.len   = r_word_len;
                        if (r_kw == KW_INT) begin
                            a_tok.kind = KIND_INT;
                        end else if (r_kw == KW_FOR) begin
                            a_tok.kind = KIND_FOR;
                        end else if (!r_first_digit) begin
                            a_tok.kind = KIND_ID;
                        end else if (r_all_digits) begin
                            a_tok.kind = KIND_NUM;
                        end else begin
                            a_tok.kind = KIND_ERR;
                        end
                        n_word_len    = '0;
                        n_word_start  = '0;
                        n_first_digit = 1'b0;
                        n_all_digits  = 1'b1;
                        n_kw          = KW_NONE;
                    end

                    if (is_space(c)) begin
                        // skip
                    end else if (c == CH_HASH) begin
                        n_stopped = 1'b1;
                    end else if (hold_code(c) != OP_NONE) begin
                        n_pend       = hold_code(c);
                        n_pend_start = r_pos;
                    end else begin
                        b_valid     = 1'b1;
                        b_tok.kind  = single_kind(c);
                        b_tok.start = r_pos;
                        b_tok.len   = LENGTH_BITS'(1);
                    end
                end
            end
        end

        // compact into slot order and mark the final token
        if (a_valid) begin
            o_tok0      = a_tok;
            o_tok1      = b_tok;
            o_tok0.last = !b_valid;
            o_tok_count = b_valid ? 2'd2 : 2'd1;
        end else begin
            o_tok0      = b_tok;
            o_tok1      = '0;
            o_tok0.last = 1'b1;
            o_tok_count = b_valid ? 2'd1 : 2'd0;
        end
        o_tok1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_len    <= '0;
            r_word_start  <= '0;
            r_first_digit <= 1'b0;
            r_all_digits  <= 1'b1;
            r_kw          <= KW_NONE;
            r_pend        <= OP_NONE;
            r_pend_start  <= '0;
            r_pos         <= '0;
            r_stopped     <= 1'b0;
        end else if (i_advance) begin
            r_word_len    <= n_word_len;
            r_word_start  <= n_word_start;
            r_first_digit <= n_first_digit;
            r_all_digits  <= n_all_digits;
            r_kw          <= n_kw;
            r_pend        <= n_pend;
            r_pend_start  <= n_pend_start;
            r_pos         <= n_pos;
            r_stopped     <= n_stopped;
        end
    end

endmodule
`default_nettype wire

### rtl/exlex_tokq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Expression lexer token queue
// Small queue that takes up to two tokens a cycle and delivers one a cycle
// on the valid/stall output channel while the output is not stalled.
// ----------------------------------------------------------------------------
module exlex_tokq
    import exlex_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_token i_tok0,
    input  wire t_token i_tok1,
    input  wire logic [1:0] i_push_count,
    output logic        o_room,
    output logic        o_valid,
    output t_token      o_tok,
    input  wire logic   i_stall
);

    t_token                 r_mem [TQ_DEPTH];
    logic [TQ_PTR_BITS-1:0] r_wptr, n_wptr;
    logic [TQ_PTR_BITS-1:0] r_rptr, n_rptr;
    logic [TQ_CNT_BITS-1:0] r_count, n_count;
    logic                   pop;
    logic [TQ_PTR_BITS-1:0] wptr_1;

    assign pop     = (r_count != '0) && !i_stall;
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rptr];
    // room for a full pair of tokens, independent of this cycle's pop
    assign o_room  = (r_count <= TQ_CNT_BITS'(TQ_DEPTH - 2));
    assign wptr_1  = r_wptr + TQ_PTR_BITS'(1);

    always_comb begin
        n_wptr  = r_wptr + TQ_PTR_BITS'(i_push_count);
        n_rptr  = pop ? r_rptr + TQ_PTR_BITS'(1) : r_rptr;
        n_count = r_count + TQ_CNT_BITS'(i_push_count) - TQ_CNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wptr] <= i_tok0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[wptr_1] <= i_tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

### rtl/expression_lexer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Expression lexer core
// Character-at-a-time tokenizer for a small expression language. Each
// input transaction carries one byte (or an end-of-input mark); each output
// transaction carries one token as kind, start position and length.
// Input channel: i_in_valid / o_in_stall, payload i_char_code and
// i_end_of_input. Output channel: o_out_valid / i_out_stall, payload
// o_token_kind, o_token_start, o_token_length and o_last_of_run, which is
// set on the last token that one character produced.
// A character lands in the input register when accepted; once the token
// queue has room for two tokens, its tokens are written into the queue,
// from which they are offered on the output channel.
// Throughput: one character per cycle while the queue has room. A character
// may yield up to two tokens; the output side drains one token per cycle
// unless stalled, so a stream dense in two-token characters is output-bound.
// The input register advances only while the four-entry token queue has
// room for two tokens; otherwise the input stalls and holds its character.
// Reset (synchronous, active low) empties the queue and the input register
// and returns the lexer to position zero with nothing pending.
// When the receiver stalls, the head token holds; the queue fills and
// then back-pressure reaches the input channel.
// ----------------------------------------------------------------------------
module expression_lexer_core
    import exlex_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [7:0]               i_char_code,
    input  wire logic                     i_end_of_input,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [KIND_BITS-1:0]          o_token_kind,
    output logic [POSITION_BITS-1:0]      o_token_start,
    output logic [LENGTH_BITS-1:0]        o_token_length,
    output logic                          o_last_of_run
);

    // Input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_char;
    logic       r_eoi;

    logic       room;
    logic       advance;
    logic       accept;
    t_token     tok0, tok1, head;
    logic [1:0] tok_count;
    logic [1:0] push_count;

    // Advance the held character into the lexer only when the queue can take
    // a full pair of tokens.
    assign advance    = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign accept     = i_in_valid && !o_in_stall;
    assign push_count = advance ? tok_count : 2'd0;

    always_comb begin
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= i_char_code;
            r_eoi  <= i_end_of_input;
        end
    end

    exlex_step u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_char_code    (r_char),
        .i_end_of_input (r_eoi),
        .o_tok0         (tok0),
        .o_tok1         (tok1),
        .o_tok_count    (tok_count)
    );

    exlex_tokq u_tokq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tok0       (tok0),
        .i_tok1       (tok1),
        .i_push_count (push_count),
        .o_room       (room),
        .o_valid      (o_out_valid),
        .o_tok        (head),
        .i_stall      (i_out_stall)
    );

    assign o_token_kind   = head.kind;
    assign o_token_start  = head.start;
    assign o_token_length = head.len;
    assign o_last_of_run  = head.last;

endmodule
`default_nettype wire

### verif/tb_expression_lexer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression lexer core testbench
// Feeds byte streams into the lexer and checks every token it emits against
// a cycle-free token predictor kept in the bench. A table of hand-picked
// characters comes first, then random fragments of source text (keywords,
// names, numbers, operators, whitespace, noise, stops, end marks), then one
// long word.
// ----------------------------------------------------------------------------
module tb_expression_lexer_core;
    import exlex_pkg::*;

    localparam logic [7:0] CH_BAR       = 8'h7C;
    localparam int         RANDOM_CHARS = 1550;
    localparam int         LONG_WORD    = 40;

    // How a directed row gets its expected tokens
    localparam logic [1:0] ROW_PREDICT = 2'd0;  // take them from the predictor
    localparam logic [1:0] ROW_NONE    = 2'd1;  // typed in: no token
    localparam logic [1:0] ROW_ONE     = 2'd2;  // typed in: exactly one token

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
        logic [1:0] mode;
        t_token     tok;
    } t_stim_row;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     in_valid     = 1'b0;
    logic                     in_stall;
    logic [7:0]               char_code    = 8'h00;
    logic                     end_of_input = 1'b0;
    logic                     out_valid;
    logic                     out_stall    = 1'b0;
    logic [KIND_BITS-1:0]     tok_kind;
    logic [POSITION_BITS-1:0] tok_start;
    logic [LENGTH_BITS-1:0]   tok_len;
    logic                     tok_last;

    // Predictor state: the lexer as the bench believes it to be
    logic [LENGTH_BITS-1:0]   lx_word_len;
    logic [POSITION_BITS-1:0] lx_word_start;
    logic                     lx_first_digit;
    logic                     lx_all_digits;
    logic [2:0]               lx_kw;
    logic [2:0]               lx_held_op;
    logic [POSITION_BITS-1:0] lx_held_start;
    logic [POSITION_BITS-1:0] lx_pos;
    logic                     lx_stopped;

    t_token    step_tokens[$];      // tokens caused by the character being lexed
    t_token    expected_tokens[$];  // tokens still owed by the DUT, oldest first
    t_stim_row directed_rows[43];

    int burst_left     = 0;
    int chars_lexed    = 0;
    int tokens_checked = 0;
    int mismatch_count = 0;
    int stall_tick     = 0;
    int stall_mode     = 0;

    logic [7:0] punct_chars[16] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN,
                                    CH_RPAREN, CH_COMMA, CH_SEMI, CH_LBRACE, CH_RBRACE,
                                    CH_EQ, CH_LT, CH_GT, CH_NOT, CH_AMP, CH_BAR};
    logic [7:0] blank_chars[4]  = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
    string      keyword_like[14] = '{"int", "for", "in", "fo", "i", "f", "intx", "fort",
                                     "iint", "forr", "Int", "FOR", "f0r", "int_"};

    expression_lexer_core i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_char_code    (char_code),
        .i_end_of_input (end_of_input),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_token_kind   (tok_kind),
        .o_token_start  (tok_start),
        .o_token_length (tok_len),
        .o_last_of_run  (tok_last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Character classes and token kinds
    // ------------------------------------------------------------------
    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_dec(c) || (c == CH_UNDER) ||
               ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_LC_A) && (c <= CH_LC_Z));
    endfunction

    function automatic logic [2:0] op_code_of(input logic [7:0] c);
        case (c)
            CH_EQ:   return OP_ASSIGN;
            CH_LT:   return OP_LT;
            CH_GT:   return OP_GT;
            CH_NOT:  return OP_NOT;
            CH_AMP:  return OP_AMP;
            default: return OP_NONE;
        endcase
    endfunction

    // Operator left alone: '!' and '&' have no kind of their own
    function automatic logic [KIND_BITS-1:0] held_alone_kind(input logic [2:0] op);
        case (op)
            OP_ASSIGN: return KIND_ASSIGN;
            OP_LT:     return KIND_LT;
            OP_GT:     return KIND_GT;
            default:   return KIND_ERR;
        endcase
    endfunction

    // Operator completed by a following '='
    function automatic logic [KIND_BITS-1:0] held_pair_kind(input logic [2:0] op);
        case (op)
            OP_ASSIGN: return KIND_EQ;
            OP_LT:     return KIND_LE;
            OP_GT:     return KIND_GE;
            default:   return KIND_NE;
        endcase
    endfunction

    function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] c);
        case (c)
            CH_PLUS:   return KIND_ADD;
            CH_MINUS:  return KIND_SUB;
            CH_STAR:   return KIND_MUL;
            CH_SLASH:  return KIND_DIV;
            CH_LPAREN: return KIND_LPAREN;
            CH_RPAREN: return KIND_RPAREN;
            CH_COMMA:  return KIND_COMMA;
            CH_SEMI:   return KIND_SEMI;
            CH_LBRACE: return KIND_LBRACE;
            CH_RBRACE: return KIND_RBRACE;
            default:   return KIND_ERR;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------
    function automatic void add_token(input logic [KIND_BITS-1:0] kind,
                                      input logic [POSITION_BITS-1:0] start,
                                      input logic [LENGTH_BITS-1:0] len);
        t_token tok;
        // only the final token of a character carries the last flag
        if (step_tokens.size() != 0)
            step_tokens[step_tokens.size() - 1].last = 1'b0;
        tok.kind  = kind;
        tok.start = start;
        tok.len   = len;
        tok.last  = 1'b1;
        step_tokens.insert(step_tokens.size(), tok);
    endfunction

    function automatic void clear_word();
        lx_word_len    = '0;
        lx_word_start  = '0;
        lx_first_digit = 1'b0;
        lx_all_digits  = 1'b1;
        lx_kw          = KW_NONE;
    endfunction

    function automatic void clear_lexer();
        clear_word();
        lx_held_op    = OP_NONE;
        lx_held_start = '0;
        lx_pos        = '0;
        lx_stopped    = 1'b0;
    endfunction

    // Advance the predictor by one input transaction; results land in step_tokens
    task automatic lex_char(input logic [7:0] c, input logic eoi);
        logic [POSITION_BITS-1:0] here;
        logic [2:0]               held;
        logic [2:0]               progress;
        logic [KIND_BITS-1:0]     kind;
        step_tokens.delete();
        // end mark: flush a held operator alone, drop a pending word, start over
        if (eoi) begin
            if (lx_held_op != OP_NONE)
                add_token(held_alone_kind(lx_held_op), lx_held_start, LENGTH_BITS'(1));
            clear_lexer();
            return;
        end
        // after '#' nothing counts until the end mark
        if (lx_stopped)
            return;
        here   = lx_pos;
        lx_pos = lx_pos + 1'b1;

        // resolve the lookahead first: either pair up or emit the operator alone
        if (lx_held_op != OP_NONE) begin
            held       = lx_held_op;
            lx_held_op = OP_NONE;
            if (held == OP_AMP && c == CH_AMP) begin
                add_token(KIND_AND, lx_held_start, LENGTH_BITS'(2));
                return;
            end
            if (held != OP_AMP && c == CH_EQ) begin
                add_token(held_pair_kind(held), lx_held_start, LENGTH_BITS'(2));
                return;
            end
            add_token(held_alone_kind(held), lx_held_start, LENGTH_BITS'(1));
        end

        // grow the word; track keyword match only over the first three characters
        if (is_ident_char(c)) begin
            progress = KW_NONE;
            if (lx_word_len == 0) begin
                lx_word_start  = here;
                lx_first_digit = is_dec(c);
                if (c == CH_LC_I)
                    progress = KW_I;
                else if (c == CH_LC_F)
                    progress = KW_F;
            end else if (lx_word_len == 1) begin
                if (lx_kw == KW_I && c == CH_LC_N)
                    progress = KW_IN;
                else if (lx_kw == KW_F && c == CH_LC_O)
                    progress = KW_FO;
            end else if (lx_word_len == 2) begin
                if (lx_kw == KW_IN && c == CH_LC_T)
                    progress = KW_INT;
                else if (lx_kw == KW_FO && c == CH_LC_R)
                    progress = KW_FOR;
            end
            lx_kw = progress;
            if (!is_dec(c))
                lx_all_digits = 1'b0;
            if (lx_word_len != {LENGTH_BITS{1'b1}})
                lx_word_len = lx_word_len + 1'b1;
            return;
        end

        // any other character closes the word
        if (lx_word_len != 0) begin
            if (lx_kw == KW_INT)
                kind = KIND_INT;
            else if (lx_kw == KW_FOR)
                kind = KIND_FOR;
            else if (!lx_first_digit)
                kind = KIND_ID;
            else if (lx_all_digits)
                kind = KIND_NUM;
            else
                kind = KIND_ERR;
            add_token(kind, lx_word_start, lx_word_len);
            clear_word();
        end

        if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)
            return;
        if (c == CH_HASH) begin
            lx_stopped = 1'b1;
            return;
        end
        if (op_code_of(c) != OP_NONE) begin
            lx_held_op    = op_code_of(c);
            lx_held_start = here;
            return;
        end
        add_token(punct_kind(c), here, LENGTH_BITS'(1));
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer one character, hold it until accepted, then record what it owes.
    // The sender runs in bursts with idle gaps in between.
    task automatic send_char(input logic [7:0] ch, input logic eoi,
                             input logic [1:0] mode, input t_token typed);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        in_valid     <= 1'b1;
        char_code    <= ch;
        end_of_input <= eoi;
        do @(posedge clk); while (in_stall !== 1'b0);
        burst_left--;
        if (eoi || !lx_stopped)
            chars_lexed++;
        lex_char(ch, eoi);
        case (mode)
            ROW_PREDICT: begin
                foreach (step_tokens[k])
                    expected_tokens.insert(expected_tokens.size(), step_tokens[k]);
            end
            ROW_ONE:     expected_tokens.insert(expected_tokens.size(), typed);
            default:     ;
        endcase
    endtask

    task automatic feed(input logic [7:0] ch, input logic eoi);
        send_char(ch, eoi, ROW_PREDICT, '0);
    endtask

    // Drop valid and hold off until every owed token has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_tokens.size() != 0);
    endtask

    function automatic logic [7:0] rand_word_char(input bit lead);
        int r;
        r = lead ? $urandom_range(10, 62) : $urandom_range(0, 62);
        if (r < 10)
            return CH_0 + 8'(r);
        if (r < 36)
            return CH_UC_A + 8'(r - 10);
        if (r < 62)
            return CH_LC_A + 8'(r - 36);
        return CH_UNDER;
    endfunction

    // One random piece of source text; mostly well formed, some noise
    task automatic send_fragment();
        int    pick;
        int    n;
        string w;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            w = keyword_like[$urandom_range(0, 13)];
            for (int k = 0; k < w.len(); k++)
                feed(w[k], 1'b0);
        end else if (pick < 32) begin
            n = $urandom_range(0, 8);
            feed(rand_word_char(1'b1), 1'b0);
            repeat (n) feed(rand_word_char(1'b0), 1'b0);
        end else if (pick < 46) begin
            n = $urandom_range(1, 6);
            repeat (n) feed(CH_0 + 8'($urandom_range(0, 9)), 1'b0);
            // a letter or underscore after digits makes a malformed number
            if ($urandom_range(0, 3) == 0)
                feed(rand_word_char(1'b1), 1'b0);
        end else if (pick < 68) begin
            feed(punct_chars[$urandom_range(0, 15)], 1'b0);
            if ($urandom_range(0, 1) == 0)
                feed(($urandom_range(0, 2) == 0) ? CH_AMP : CH_EQ, 1'b0);
        end else if (pick < 84) begin
            repeat ($urandom_range(1, 3)) feed(blank_chars[$urandom_range(0, 3)], 1'b0);
        end else if (pick < 94) begin
            feed(8'($urandom_range(0, 255)), 1'b0);
        end else if (pick < 97) begin
            // stop, a few ignored bytes, then the end mark that revives the lexer
            feed(CH_HASH, 1'b0);
            repeat ($urandom_range(0, 4)) feed(8'($urandom_range(0, 255)), 1'b0);
            feed(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            feed(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    function automatic t_stim_row stim_row(input logic [7:0] ch, input logic eoi,
                                           input logic [1:0] mode,
                                           input logic [KIND_BITS-1:0] kind = KIND_ERR,
                                           input int start = 0,
                                           input int len = 0);
        t_stim_row row;
        row.ch        = ch;
        row.eoi       = eoi;
        row.mode      = mode;
        row.tok.kind  = kind;
        row.tok.start = POSITION_BITS'(start);
        row.tok.len   = LENGTH_BITS'(len);
        row.tok.last  = 1'b1;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: stall on a pattern that is redrawn at random from four modes.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        stall_tick++;
        if (stall_tick % 300 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       out_stall <= 1'b0;                          // drain freely
            1:       out_stall <= ($urandom_range(0, 1) == 0);   // coin toss
            2:       out_stall <= ((stall_tick % 8) < 5);        // periodic, mostly stalled
            default: out_stall <= ($urandom_range(0, 9) < 8);    // heavy random back-pressure
        endcase
    end

    // ------------------------------------------------------------------
    // Token checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH at %0t, token %0d: %s got %0d want %0d",
                 $realtime, tokens_checked, what, got, want);
    endtask

    always @(posedge clk) begin : token_monitor
        t_token want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch("token with none owed, kind", 32'(tok_kind), 0);
            end else begin
                want = expected_tokens.pop_front();
                if (tok_kind !== want.kind)
                    report_mismatch("kind", 32'(tok_kind), 32'(want.kind));
                if (tok_start !== want.start)
                    report_mismatch("start", 32'(tok_start), 32'(want.start));
                if (tok_len !== want.len)
                    report_mismatch("length", 32'(tok_len), 32'(want.len));
                if (tok_last !== want.last)
                    report_mismatch("last flag", 32'(tok_last), 32'(want.last));
            end
            tokens_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int random_target;
        int fragments;
        int guard;

        // Positions restart at zero after reset and after each end mark
        directed_rows = '{
            stim_row(CH_LC_I,   1'b0, ROW_NONE),
            stim_row(CH_LC_N,   1'b0, ROW_NONE),
            stim_row(CH_LC_T,   1'b0, ROW_NONE),
            stim_row(CH_SPACE,  1'b0, ROW_ONE, KIND_INT, 0, 3),
            stim_row(CH_LC_F,   1'b0, ROW_NONE),
            stim_row(CH_LC_O,   1'b0, ROW_NONE),
            stim_row(CH_LC_R,   1'b0, ROW_NONE),
            stim_row(CH_LPAREN, 1'b0, ROW_PREDICT),         // keyword and paren together
            stim_row(CH_LT,     1'b0, ROW_NONE),
            stim_row(CH_EQ,     1'b0, ROW_ONE, KIND_LE, 8, 2),
            stim_row(CH_NOT,    1'b0, ROW_NONE),
            stim_row("x",       1'b0, ROW_ONE, KIND_ERR, 10, 1),  // lone '!'
            stim_row(CH_AMP,    1'b0, ROW_PREDICT),
            stim_row(CH_AMP,    1'b0, ROW_ONE, KIND_AND, 12, 2),
            stim_row(CH_9,      1'b0, ROW_NONE),
            stim_row(CH_UC_Z,   1'b0, ROW_NONE),
            stim_row(8'hFF,     1'b0, ROW_PREDICT),         // bad word, then high byte
            stim_row(8'h00,     1'b0, ROW_ONE, KIND_ERR, 17, 1),
            stim_row(CH_BAR,    1'b0, ROW_ONE, KIND_ERR, 18, 1),
            stim_row(CH_GT,     1'b0, ROW_NONE),
            stim_row(CH_HASH,   1'b0, ROW_ONE, KIND_GT, 19, 1),
            stim_row(CH_PLUS,   1'b0, ROW_NONE),            // ignored while stopped
            stim_row(8'h00,     1'b1, ROW_NONE),
            stim_row(CH_EQ,     1'b0, ROW_NONE),
            stim_row(8'hFF,     1'b1, ROW_ONE, KIND_ASSIGN, 0, 1),
            stim_row(CH_0 + 8'd4, 1'b0, ROW_NONE),
            stim_row(CH_0 + 8'd2, 1'b0, ROW_NONE),
            stim_row(CH_GT,     1'b0, ROW_PREDICT),
            stim_row(CH_EQ,     1'b0, ROW_ONE, KIND_GE, 2, 2),
            stim_row(CH_NOT,    1'b0, ROW_NONE),
            stim_row(CH_EQ,     1'b0, ROW_ONE, KIND_NE, 4, 2),
            stim_row(CH_MINUS,  1'b0, ROW_ONE, KIND_SUB, 6, 1),
            stim_row(CH_STAR,   1'b0, ROW_ONE, KIND_MUL, 7, 1),
            stim_row(CH_SLASH,  1'b0, ROW_PREDICT),
            stim_row(CH_RPAREN, 1'b0, ROW_PREDICT),
            stim_row(CH_COMMA,  1'b0, ROW_PREDICT),
            stim_row(CH_SEMI,   1'b0, ROW_PREDICT),
            stim_row(CH_LBRACE, 1'b0, ROW_PREDICT),
            stim_row(CH_RBRACE, 1'b0, ROW_PREDICT),
            stim_row(CH_UNDER,  1'b0, ROW_NONE),
            stim_row(CH_EQ,     1'b0, ROW_PREDICT),
            stim_row(CH_EQ,     1'b0, ROW_ONE, KIND_EQ, 15, 2),
            stim_row(8'h55,     1'b1, ROW_NONE)
        };

        clear_lexer();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        for (int r = 0; r < $size(directed_rows); r++)
            send_char(directed_rows[r].ch, directed_rows[r].eoi,
                      directed_rows[r].mode, directed_rows[r].tok);
        wait_drained();

        // Random text; now and then starve the input until the queue empties
        random_target = chars_lexed + RANDOM_CHARS;
        fragments     = 0;
        while (chars_lexed < random_target) begin
            send_fragment();
            fragments++;
            if (fragments % 97 == 96)
                wait_drained();
        end
        wait_drained();

        // One long word, closed by a semicolon
        feed(8'h00, 1'b1);
        feed(CH_LC_A + 8'($urandom_range(0, 25)), 1'b0);
        repeat (LONG_WORD - 1) feed(rand_word_char(1'b0), 1'b0);
        feed(CH_SEMI, 1'b0);

        // Drain, with a bound, then let the pipeline settle
        in_valid <= 1'b0;
        guard = 0;
        do begin
            @(posedge clk);
            guard++;
        end while (expected_tokens.size() != 0 && guard < 100000);
        if (expected_tokens.size() != 0)
            report_mismatch("tokens never delivered, count", expected_tokens.size(), 0);
        repeat (8) @(posedge clk);

        $display("Run covered %0d lexed characters: directed table, %0d random fragments,",
                 chars_lexed, fragments);
        $display("and a %0d-character word; %0d tokens checked, %0d mismatches.",
                 LONG_WORD, tokens_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("[expression_lexer_core] OK");
        else
            $display("[expression_lexer_core] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #30_000_000;
        $display("[expression_lexer_core] ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/exlex_pkg.sv
rtl/exlex_step.sv
rtl/exlex_tokq.sv
rtl/expression_lexer_core.sv
verif/tb_expression_lexer_core.sv
